@@ rtl/i2cbm_pkg.sv @@
`timescale 1ns / 1ps

package i2cbm_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0] AckWaitReset = 8'd7;
    localparam logic [7:0] MsbMask      = 8'h80;
    localparam logic [3:0] BitsPerByte  = 4'd8;

    // Sub-steps inside a bus phase
    localparam logic [1:0] SubFirst  = 2'd0;
    localparam logic [1:0] SubSecond = 2'd1;
    localparam logic [1:0] SubThird  = 2'd2;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_CMD  = 1'b1
    } item_kind_t;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_WBIT  = 7'b0000100,
        PH_ACK   = 7'b0001000,
        PH_RBIT  = 7'b0010000,
        PH_NACK  = 7'b0100000,
        PH_STOP  = 7'b1000000
    } phase_t;

    // Classified item as it sits in the queue
    typedef struct packed {
        item_kind_t kind;
        logic       cmd_read;
        logic       cmd_start;
        logic       cmd_stop;
        logic [7:0] cmd_data;
        logic       sda_in;
    } queue_item_t;

    // Result of one item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       cmd_rejected;
    } result_t;

endpackage

@@ rtl/i2cbm_front.sv @@
`timescale 1ns / 1ps

module i2cbm_front #(
    parameter int QUEUE_DEPTH = i2cbm_pkg::QueueDepth
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic                   s_cmd_read,
    input  logic [7:0]             s_cmd_data,
    input  logic                   s_cmd_start,
    input  logic                   s_cmd_stop,
    input  logic                   s_sda_in,
    output logic                   q_valid,
    output i2cbm_pkg::queue_item_t q_item,
    input  logic                   q_pop
);

    localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CountW = $clog2(QUEUE_DEPTH + 1);

    i2cbm_pkg::queue_item_t mem_reg [QUEUE_DEPTH];
    i2cbm_pkg::queue_item_t push_item;

    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign s_ready = (count_reg < CountW'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    // Classify: a tick keeps only the sampled line, a command drops it
    always_comb begin
        push_item = '0;
        if (s_mode) begin
            push_item.kind      = i2cbm_pkg::KIND_CMD;
            push_item.cmd_read  = s_cmd_read;
            push_item.cmd_start = s_cmd_start;
            push_item.cmd_stop  = s_cmd_stop;
            push_item.cmd_data  = s_cmd_data;
        end else begin
            push_item.kind   = i2cbm_pkg::KIND_TICK;
            push_item.sda_in = s_sda_in;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

@@ rtl/i2cbm_engine.sv @@
`timescale 1ns / 1ps

module i2cbm_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   q_valid,
    input  i2cbm_pkg::queue_item_t q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output i2cbm_pkg::result_t     m_result
);

    i2cbm_pkg::phase_t  phase_reg, phase_next;
    i2cbm_pkg::result_t res_reg, res_next;

    logic [7:0] ack_wait_limit_reg;
    logic [1:0] sub_reg, sub_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       flag_start_reg, flag_start_next;
    logic       flag_read_reg, flag_read_next;
    logic       flag_stop_reg, flag_stop_next;
    logic       ack_flag_reg, ack_flag_next;
    logic       out_valid_reg;
    logic       o_scl, o_sda, finish, rej;
    logic [3:0] bit_inc;

    assign q_pop    = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = res_reg;
    assign bit_inc  = bit_count_reg + 1'b1;

    always_comb begin
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        wait_count_next = wait_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        flag_start_next = flag_start_reg;
        flag_read_next  = flag_read_reg;
        flag_stop_next  = flag_stop_reg;
        ack_flag_next   = ack_flag_reg;
        o_scl           = scl_reg;
        o_sda           = sda_reg;
        finish          = 1'b0;
        rej             = 1'b0;

        if (q_item.kind == i2cbm_pkg::KIND_CMD) begin
            if (phase_reg != i2cbm_pkg::PH_IDLE) begin
                rej = 1'b1;
            end else begin
                flag_start_next = q_item.cmd_start;
                flag_read_next  = q_item.cmd_read;
                flag_stop_next  = q_item.cmd_stop;
                shift_next      = q_item.cmd_data;
                ack_flag_next   = 1'b0;
                sub_next        = i2cbm_pkg::SubFirst;
                if (q_item.cmd_start) begin
                    phase_next = i2cbm_pkg::PH_START;
                end else begin
                    bit_count_next = '0;
                    phase_next = q_item.cmd_read ? i2cbm_pkg::PH_RBIT : i2cbm_pkg::PH_WBIT;
                end
            end
        end else begin
            case (phase_reg)
                i2cbm_pkg::PH_START: begin
                    if (sub_reg == i2cbm_pkg::SubFirst) begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        sub_next = i2cbm_pkg::SubSecond;
                    end else if (sub_reg == i2cbm_pkg::SubSecond) begin
                        sda_next = 1'b0;
                        sub_next = i2cbm_pkg::SubThird;
                    end else begin
                        scl_next       = 1'b0;
                        sub_next       = i2cbm_pkg::SubFirst;
                        bit_count_next = '0;
                        phase_next     = flag_read_reg ? i2cbm_pkg::PH_RBIT
                                                       : i2cbm_pkg::PH_WBIT;
                    end
                    o_scl = scl_next;
                    o_sda = sda_next;
                end
                i2cbm_pkg::PH_WBIT: begin
                    if (sub_reg == i2cbm_pkg::SubFirst) begin
                        sda_next = |(shift_reg & i2cbm_pkg::MsbMask);
                        sub_next = i2cbm_pkg::SubSecond;
                    end else if (sub_reg == i2cbm_pkg::SubSecond) begin
                        scl_next = 1'b1;
                        sub_next = i2cbm_pkg::SubThird;
                    end else begin
                        scl_next       = 1'b0;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_inc;
                        sub_next       = i2cbm_pkg::SubFirst;
                        if (bit_inc >= i2cbm_pkg::BitsPerByte) begin
                            phase_next      = i2cbm_pkg::PH_ACK;
                            wait_count_next = ack_wait_limit_reg;
                        end
                    end
                    o_scl = scl_next;
                    o_sda = sda_next;
                end
                i2cbm_pkg::PH_ACK: begin
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                    o_scl           = 1'b1;
                    o_sda           = 1'b1;
                    wait_count_next = wait_count_reg - 1'b1;
                    if (!q_item.sda_in) begin
                        ack_flag_next = 1'b1;
                        finish        = 1'b1;
                    end else if (wait_count_next == '0) begin
                        ack_flag_next = 1'b0;
                        finish        = 1'b1;
                    end
                    if (finish) begin
                        scl_next = 1'b0;
                        // a pending stop takes over before the command reports done
                        if (flag_stop_reg) begin
                            finish     = 1'b0;
                            phase_next = i2cbm_pkg::PH_STOP;
                            sub_next   = i2cbm_pkg::SubFirst;
                        end
                    end
                end
                i2cbm_pkg::PH_RBIT: begin
                    if (sub_reg == i2cbm_pkg::SubFirst) begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        shift_next = {shift_reg[6:0], q_item.sda_in};
                        sub_next   = i2cbm_pkg::SubSecond;
                    end else begin
                        scl_next       = 1'b0;
                        bit_count_next = bit_inc;
                        sub_next       = i2cbm_pkg::SubFirst;
                        if (bit_inc >= i2cbm_pkg::BitsPerByte) begin
                            phase_next = i2cbm_pkg::PH_NACK;
                        end
                    end
                    o_scl = scl_next;
                    o_sda = sda_next;
                end
                i2cbm_pkg::PH_NACK: begin
                    if (sub_reg == i2cbm_pkg::SubFirst) begin
                        sda_next = 1'b1;
                        sub_next = i2cbm_pkg::SubSecond;
                        o_scl    = scl_reg;
                        o_sda    = 1'b1;
                    end else begin
                        // clock pulse is shown this unit, SCL drops after it
                        o_scl    = 1'b1;
                        o_sda    = sda_reg;
                        scl_next = 1'b0;
                        if (flag_stop_reg) begin
                            phase_next = i2cbm_pkg::PH_STOP;
                            sub_next   = i2cbm_pkg::SubFirst;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
                i2cbm_pkg::PH_STOP: begin
                    if (sub_reg == i2cbm_pkg::SubFirst) begin
                        sda_next = 1'b0;
                        sub_next = i2cbm_pkg::SubSecond;
                        o_scl    = scl_reg;
                        o_sda    = 1'b0;
                    end else if (sub_reg == i2cbm_pkg::SubSecond) begin
                        scl_next = 1'b1;
                        sub_next = i2cbm_pkg::SubThird;
                        o_scl    = 1'b1;
                        o_sda    = sda_reg;
                    end else begin
                        sda_next = 1'b1;
                        o_scl    = scl_reg;
                        o_sda    = 1'b1;
                        scl_next = 1'b0;
                        finish   = 1'b1;
                    end
                end
                default: begin
                    phase_next = i2cbm_pkg::PH_IDLE;
                end
            endcase

            if (finish) begin
                phase_next     = i2cbm_pkg::PH_IDLE;
                sub_next       = i2cbm_pkg::SubFirst;
                bit_count_next = '0;
            end
        end

        res_next.scl_level    = o_scl;
        res_next.sda_level    = o_sda;
        res_next.busy_res     = (phase_next != i2cbm_pkg::PH_IDLE);
        res_next.done_res     = finish;
        res_next.read_byte    = (finish && flag_read_reg) ? shift_next : 8'd0;
        res_next.ack_seen     = finish && !flag_read_reg && ack_flag_next;
        res_next.cmd_rejected = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_wait_limit_reg <= i2cbm_pkg::AckWaitReset;
            phase_reg          <= i2cbm_pkg::PH_IDLE;
            sub_reg            <= i2cbm_pkg::SubFirst;
            bit_count_reg      <= '0;
            shift_reg          <= '0;
            wait_count_reg     <= '0;
            scl_reg            <= 1'b1;
            sda_reg            <= 1'b1;
            flag_start_reg     <= 1'b0;
            flag_read_reg      <= 1'b0;
            flag_stop_reg      <= 1'b0;
            ack_flag_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                ack_wait_limit_reg <= cfg_wdata;
            end
            if (q_pop) begin
                phase_reg      <= phase_next;
                sub_reg        <= sub_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                wait_count_reg <= wait_count_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                flag_start_reg <= flag_start_next;
                flag_read_reg  <= flag_read_next;
                flag_stop_reg  <= flag_stop_next;
                ack_flag_reg   <= ack_flag_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.cmd_rejected |-> res_reg.busy_res)
        else $error("command rejected while idle");

    a_ack_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.ack_seen |-> res_reg.done_res && !flag_read_reg)
        else $error("acknowledge flagged outside a finished write");

    a_pop_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> out_valid_reg)
        else $error("popped transaction did not reach the output register");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result lost");

endmodule

@@ rtl/i2c_byte_master.sv @@
`timescale 1ns / 1ps

// Byte-level I2C master sequencer.
// Input channel (s_valid/s_ready): each transaction is either a byte command
// (s_mode = 1: start, write or read, stop flags and data) or a tick
// (s_mode = 0) that stands for one bus delay unit and carries sampled SDA.
// Result channel (m_valid/m_ready): exactly one result per input transaction,
// in order: SCL/SDA levels for the unit, busy, done, read byte, ack, reject.
// A command that arrives while a byte is in progress is dropped and flagged.
// Config: cfg_we/cfg_wdata write the acknowledge wait limit (reset 7) and
// must only be used while no transaction is in flight.
// An accepted input is written to the queue, then its result is presented from
// the result register; it waits in the queue while older transactions are pending.
// Throughput: one transaction per cycle while m_ready stays high; the bus
// sequencer advances one step per popped queue entry. A QUEUE_DEPTH-entry
// queue sits between the classifying front and the sequencer, and the result
// register decouples the sequencer from m_ready: on a stall the result holds,
// the queue fills and s_ready drops only when it is full.
// Reset (aresetn low, synchronous): queue empty, sequencer idle, both bus
// lines released, no result pending.
module i2c_byte_master #(
    parameter int QUEUE_DEPTH = i2cbm_pkg::QueueDepth
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic       s_cmd_read,
    input  logic [7:0] s_cmd_data,
    input  logic       s_cmd_start,
    input  logic       s_cmd_stop,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_byte,
    output logic       m_ack_seen,
    output logic       m_cmd_rejected
);

    i2cbm_pkg::queue_item_t q_item;
    i2cbm_pkg::result_t     result;
    logic                   q_valid;
    logic                   q_pop;

    i2cbm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_cmd_read  (s_cmd_read),
        .s_cmd_data  (s_cmd_data),
        .s_cmd_start (s_cmd_start),
        .s_cmd_stop  (s_cmd_stop),
        .s_sda_in    (s_sda_in),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    i2cbm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_scl_level    = result.scl_level;
    assign m_sda_level    = result.sda_level;
    assign m_busy_res     = result.busy_res;
    assign m_done_res     = result.done_res;
    assign m_read_byte    = result.read_byte;
    assign m_ack_seen     = result.ack_seen;
    assign m_cmd_rejected = result.cmd_rejected;

endmodule

@@ tb/i2c_byte_master_tb.sv @@
`timescale 1ns / 1ps

module i2c_byte_master_tb;

    class i2c_bus_scoreboard;
        i2cbm_pkg::phase_t  phase;
        logic [1:0]         sub;
        logic [3:0]         nbits;
        logic [7:0]         shreg;
        logic [7:0]         wait_cnt;
        logic               scl_r;
        logic               sda_r;
        logic               want_stop;
        logic               want_read;
        logic               want_start;
        logic               ack_flag;
        logic [7:0]         ack_limit;
        i2cbm_pkg::result_t expected_levels[$];
        int                 mismatch_count;

        function new();
            phase = i2cbm_pkg::PH_IDLE;
            sub = i2cbm_pkg::SubFirst;
            nbits = '0;
            shreg = '0;
            wait_cnt = '0;
            scl_r = 1'b1;
            sda_r = 1'b1;
            want_stop = 1'b0;
            want_read = 1'b0;
            want_start = 1'b0;
            ack_flag = 1'b0;
            ack_limit = i2cbm_pkg::AckWaitReset;
            mismatch_count = 0;
        endfunction

        function void enter_byte();
            sub = i2cbm_pkg::SubFirst;
            nbits = '0;
            phase = want_read ? i2cbm_pkg::PH_RBIT : i2cbm_pkg::PH_WBIT;
        endfunction

        function void note_item(i2cbm_pkg::item_kind_t kind, logic rd, logic [7:0] data,
                                logic st, logic sp, logic sda);
            i2cbm_pkg::result_t r;
            logic               finish;
            r = '0;
            finish = 1'b0;
            if (kind == i2cbm_pkg::KIND_CMD) begin
                if (phase != i2cbm_pkg::PH_IDLE) begin
                    r.cmd_rejected = 1'b1;
                end else begin
                    want_stop = sp;
                    want_read = rd;
                    want_start = st;
                    shreg = data;
                    ack_flag = 1'b0;
                    if (st) begin
                        phase = i2cbm_pkg::PH_START;
                        sub = i2cbm_pkg::SubFirst;
                    end else begin
                        enter_byte();
                    end
                end
                r.scl_level = scl_r;
                r.sda_level = sda_r;
            end else begin
                case (phase)
                    i2cbm_pkg::PH_START: begin
                        if (sub == i2cbm_pkg::SubFirst) begin
                            scl_r = 1'b1;
                            sda_r = 1'b1;
                            sub = i2cbm_pkg::SubSecond;
                        end else if (sub == i2cbm_pkg::SubSecond) begin
                            sda_r = 1'b0;
                            sub = i2cbm_pkg::SubThird;
                        end else begin
                            scl_r = 1'b0;
                            enter_byte();
                        end
                        r.scl_level = scl_r;
                        r.sda_level = sda_r;
                    end
                    i2cbm_pkg::PH_WBIT: begin
                        if (sub == i2cbm_pkg::SubFirst) begin
                            sda_r = (shreg & i2cbm_pkg::MsbMask) != 0;
                            sub = i2cbm_pkg::SubSecond;
                        end else if (sub == i2cbm_pkg::SubSecond) begin
                            scl_r = 1'b1;
                            sub = i2cbm_pkg::SubThird;
                        end else begin
                            scl_r = 1'b0;
                            shreg = shreg << 1;
                            nbits = nbits + 1'b1;
                            sub = i2cbm_pkg::SubFirst;
                            if (nbits >= i2cbm_pkg::BitsPerByte) begin
                                phase = i2cbm_pkg::PH_ACK;
                                wait_cnt = ack_limit;
                            end
                        end
                        r.scl_level = scl_r;
                        r.sda_level = sda_r;
                    end
                    i2cbm_pkg::PH_ACK: begin
                        scl_r = 1'b1;
                        sda_r = 1'b1;
                        r.scl_level = 1'b1;
                        r.sda_level = 1'b1;
                        wait_cnt = wait_cnt - 1'b1;
                        if (!sda) begin
                            ack_flag = 1'b1;
                            finish = 1'b1;
                        end else if (wait_cnt == 0) begin
                            ack_flag = 1'b0;
                            finish = 1'b1;
                        end
                        if (finish) begin
                            // SCL drops after the acknowledge clock
                            scl_r = 1'b0;
                            if (want_stop) begin
                                finish = 1'b0;
                                phase = i2cbm_pkg::PH_STOP;
                                sub = i2cbm_pkg::SubFirst;
                            end
                        end
                    end
                    i2cbm_pkg::PH_RBIT: begin
                        if (sub == i2cbm_pkg::SubFirst) begin
                            scl_r = 1'b1;
                            sda_r = 1'b1;
                            shreg = {shreg[6:0], sda};
                            sub = i2cbm_pkg::SubSecond;
                        end else begin
                            scl_r = 1'b0;
                            nbits = nbits + 1'b1;
                            sub = i2cbm_pkg::SubFirst;
                            if (nbits >= i2cbm_pkg::BitsPerByte) phase = i2cbm_pkg::PH_NACK;
                        end
                        r.scl_level = scl_r;
                        r.sda_level = sda_r;
                    end
                    i2cbm_pkg::PH_NACK: begin
                        if (sub == i2cbm_pkg::SubFirst) begin
                            sda_r = 1'b1;
                            sub = i2cbm_pkg::SubSecond;
                            r.scl_level = scl_r;
                            r.sda_level = sda_r;
                        end else begin
                            r.scl_level = 1'b1;
                            r.sda_level = sda_r;
                            scl_r = 1'b0;
                            if (want_stop) begin
                                phase = i2cbm_pkg::PH_STOP;
                                sub = i2cbm_pkg::SubFirst;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                    end
                    i2cbm_pkg::PH_STOP: begin
                        if (sub == i2cbm_pkg::SubFirst) begin
                            sda_r = 1'b0;
                            sub = i2cbm_pkg::SubSecond;
                            r.scl_level = scl_r;
                            r.sda_level = sda_r;
                        end else if (sub == i2cbm_pkg::SubSecond) begin
                            scl_r = 1'b1;
                            sub = i2cbm_pkg::SubThird;
                            r.scl_level = scl_r;
                            r.sda_level = sda_r;
                        end else begin
                            sda_r = 1'b1;
                            r.scl_level = scl_r;
                            r.sda_level = 1'b1;
                            scl_r = 1'b0;
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        phase = i2cbm_pkg::PH_IDLE;
                        r.scl_level = scl_r;
                        r.sda_level = sda_r;
                    end
                endcase
                if (finish) begin
                    r.done_res = 1'b1;
                    if (want_read) r.read_byte = shreg;
                    else r.ack_seen = ack_flag;
                    phase = i2cbm_pkg::PH_IDLE;
                    sub = i2cbm_pkg::SubFirst;
                    nbits = '0;
                end
            end
            r.busy_res = phase != i2cbm_pkg::PH_IDLE;
            expected_levels.push_back(r);
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            if (mismatch_count < 100)
                $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
            mismatch_count++;
        endtask

        task check_result(i2cbm_pkg::result_t got);
            i2cbm_pkg::result_t want;
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result", 8'h00, 8'h00);
            end else begin
                want = expected_levels.pop_front();
                if (got.scl_level !== want.scl_level)
                    report_mismatch("scl_level", 8'(got.scl_level), 8'(want.scl_level));
                if (got.sda_level !== want.sda_level)
                    report_mismatch("sda_level", 8'(got.sda_level), 8'(want.sda_level));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.ack_seen !== want.ack_seen)
                    report_mismatch("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
                if (got.cmd_rejected !== want.cmd_rejected)
                    report_mismatch("cmd_rejected", 8'(got.cmd_rejected),
                                    8'(want.cmd_rejected));
            end
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_mode = 1'b0;
    logic       s_cmd_read = 1'b0;
    logic [7:0] s_cmd_data = '0;
    logic       s_cmd_start = 1'b0;
    logic       s_cmd_stop = 1'b0;
    logic       s_sda_in = 1'b1;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_scl_level;
    logic       m_sda_level;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_byte;
    logic       m_ack_seen;
    logic       m_cmd_rejected;

    i2c_bus_scoreboard sb = new();

    bit calm_stretch;
    bit hold_nack;
    int ack_delay;
    int items_sent;
    int stall_left;

    i2c_byte_master dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_cmd_read    (s_cmd_read),
        .s_cmd_data    (s_cmd_data),
        .s_cmd_start   (s_cmd_start),
        .s_cmd_stop    (s_cmd_stop),
        .s_sda_in      (s_sda_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_level   (m_sda_level),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_read_byte   (m_read_byte),
        .m_ack_seen    (m_ack_seen),
        .m_cmd_rejected(m_cmd_rejected)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function int pick_gap();
        int r;
        if (calm_stretch) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stalls, check every transaction
    always @(posedge aclk) begin
        i2cbm_pkg::result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.scl_level = m_scl_level;
                got.sda_level = m_sda_level;
                got.busy_res = m_busy_res;
                got.done_res = m_done_res;
                got.read_byte = m_read_byte;
                got.ack_seen = m_ack_seen;
                got.cmd_rejected = m_cmd_rejected;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
            end
        end
    end

    task send_item(i2cbm_pkg::item_kind_t kind, logic rd, logic [7:0] data, logic st,
                   logic sp, logic sda);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= kind;
        s_cmd_read <= rd;
        s_cmd_data <= data;
        s_cmd_start <= st;
        s_cmd_stop <= sp;
        s_sda_in <= sda;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, rd, data, st, sp, sda);
        items_sent++;
    endtask

    // Tick with random ignored command fields; SDA follows the acknowledge plan
    task send_tick();
        logic sda;
        sda = rand_bit();
        if (sb.phase == i2cbm_pkg::PH_ACK) begin
            if (hold_nack) begin
                sda = 1'b1;
            end else if (ack_delay == 0) begin
                sda = 1'b0;
            end else begin
                ack_delay--;
                sda = 1'b1;
            end
        end
        send_item(i2cbm_pkg::KIND_TICK, rand_bit(), rand_byte(), rand_bit(), rand_bit(), sda);
    endtask

    // Valid is already low when nothing is outstanding
    task wait_for_results();
        if (sb.expected_levels.size() != 0) begin
            s_valid <= 1'b0;
            while (sb.expected_levels.size() != 0) @(posedge aclk);
        end
    endtask

    task set_ack_limit(logic [7:0] value);
        hold_nack = 1'b0;
        ack_delay = 0;
        while (sb.phase != i2cbm_pkg::PH_IDLE) send_tick();
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.ack_limit = value;
    endtask

    task run_random_command();
        int n;
        calm_stretch = ($urandom_range(0, 4) == 0);
        hold_nack = ($urandom_range(0, 9) == 0);
        ack_delay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
        if ($urandom_range(0, 24) == 0) wait_for_results();
        // Noise: raw items of either kind with random content
        if ($urandom_range(0, 11) == 0) begin
            n = $urandom_range(1, 5);
            repeat (n)
                send_item(i2cbm_pkg::item_kind_t'(rand_bit()), rand_bit(), rand_byte(),
                          rand_bit(), rand_bit(), rand_bit());
        end
        send_item(i2cbm_pkg::KIND_CMD, rand_bit(), rand_byte(),
                  $urandom_range(0, 3) != 0, rand_bit(), rand_bit());
        while (sb.phase != i2cbm_pkg::PH_IDLE) begin
            // Drop in a command while busy now and then
            if ($urandom_range(0, 39) == 0)
                send_item(i2cbm_pkg::KIND_CMD, rand_bit(), rand_byte(),
                          rand_bit(), rand_bit(), rand_bit());
            else
                send_tick();
        end
        if ($urandom_range(0, 3) == 0) send_tick();
    endtask

    initial begin
        logic [7:0] limits[5];
        int phase_end;
        limits[0] = 8'd1;
        limits[1] = 8'd255;
        limits[2] = 8'd0;
        limits[3] = 8'($urandom_range(2, 254));
        limits[4] = i2cbm_pkg::AckWaitReset;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, bare read with a rejected command inside
        calm_stretch = 1'b0;
        hold_nack = 1'b0;
        ack_delay = 0;
        send_item(i2cbm_pkg::KIND_TICK, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(i2cbm_pkg::KIND_CMD, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
        send_item(i2cbm_pkg::KIND_CMD, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0);
        while (sb.phase != i2cbm_pkg::PH_IDLE) send_tick();
        send_item(i2cbm_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);

        foreach (limits[i]) begin
            set_ack_limit(limits[i]);
            phase_end = items_sent + 350;
            while (items_sent < phase_end) run_random_command();
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.expected_levels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
